>>> hw/rtl/dtq_pkg.sv
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

  localparam int          DEADLINE_W  = 32;
  localparam int          ID_W        = 16;
  localparam int          TIMEOUT_W   = 25;
  localparam int          MAX_RESULTS = 16;
  localparam int          RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam logic [15:0] ID_ALL      = 16'hFFFF;
  localparam logic [31:0] KEY_BIAS    = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EXPIRED   = 3'd5
  } status_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [ID_W-1:0]       id;
  } entry_t;

  // verdict of the compare unit on one entry
  typedef struct packed {
    logic                  due;
    logic                  better;
    logic [DEADLINE_W-1:0] key;
  } eval_t;

endpackage

>>> hw/rtl/dtq_if.sv
// Valid/ready channel interfaces for the request and result streams.
interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic signed [24:0] timeout_ms;
  logic [15:0] task_id;

  modport source (output valid, output op, output timeout_ms, output task_id, input ready);
  modport sink   (input valid, input op, input timeout_ms, input task_id, output ready);
endinterface

interface dtq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_id;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output result_id, output status, output last, input ready);
  modport sink   (input valid, input result_id, input status, input last, output ready);
endinterface

>>> hw/rtl/deadline_timer_queue.sv
// Deadline timer queue top level.
// Pending one-shot timeouts live in a RAM (deadline and id per slot) with a
// valid bit per slot in flops. An add or a cancel-all is decided in the idle
// state and then waits in S_EMIT for the output register. A cancel by id reads
// the RAM one slot per cycle. A tick that expires k entries makes k + 1 passes
// over the RAM (k passes when it reaches the limit of 16), and holds each found
// entry back one pass so that the final one can carry last; at most 16 entries
// expire per tick. The single RAM read port limits each scan to one slot per
// cycle. Requests are taken one at a time; a finished result sits in the output
// register while the next request enters.
module deadline_timer_queue #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  dtq_in_if.sink    in_chan,
  dtq_out_if.source out_chan
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RCW   = dtq_pkg::RES_CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_TNEXT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [31:0] best_key_r, best_key_nxt;
  logic [15:0] best_id_r, best_id_nxt;
  logic is_tick_r, is_tick_nxt;
  logic [15:0] task_r, task_nxt;
  logic pend_r, pend_nxt;
  logic [15:0] pend_id_r, pend_id_nxt;
  logic [RCW-1:0] cnt_r, cnt_nxt;
  logic [15:0] res_id_r, res_id_nxt;
  dtq_pkg::status_t res_status_r, res_status_nxt;
  logic res_last_r, res_last_nxt;
  logic ret_tnext_r, ret_tnext_nxt;
  logic out_vld_r, out_vld_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  dtq_pkg::status_t out_status_r, out_status_nxt;
  logic out_last_r, out_last_nxt;

  logic ram_we;
  dtq_pkg::entry_t ram_wdata, ram_rdata;
  logic [IDX_W-1:0] ram_raddr;

  logic free_found;
  logic [IDX_W-1:0] free_idx;
  logic bad_timeout;
  logic [15:0] nid_inc, nid_step;
  logic scan_end;
  logic out_free;
  dtq_pkg::eval_t ev;

  dtq_ram #(
    .WIDTH($bits(dtq_pkg::entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dtq_sel u_sel (
    .now_ms    (now_r),
    .cand      (ram_rdata),
    .best_found(found_r),
    .best_key  (best_key_r),
    .best_id   (best_id_r),
    .ev        (ev)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign bad_timeout = (in_chan.timeout_ms == '0) || in_chan.timeout_ms[24];
  assign nid_inc     = next_id_r + 16'd1;
  assign nid_step    = ((nid_inc == '0) || (nid_inc == dtq_pkg::ID_ALL)) ? 16'd1 : nid_inc;
  assign ram_wdata.deadline = now_r + {8'd0, in_chan.timeout_ms[23:0]};
  assign ram_wdata.id       = next_id_r;
  assign ram_raddr   = scan_idx_r[IDX_W-1:0];
  assign scan_end    = (scan_idx_r == CNT_W'(TABLE_DEPTH)) && !chk_vld_r;
  assign out_free    = !out_vld_r || out_chan.ready;

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = out_vld_r;
  assign out_chan.result_id = out_id_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.last      = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    now_nxt        = now_r;
    next_id_nxt    = next_id_r;
    scan_idx_nxt   = scan_idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_id_nxt    = best_id_r;
    is_tick_nxt    = is_tick_r;
    task_nxt       = task_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    cnt_nxt        = cnt_r;
    res_id_nxt     = res_id_r;
    res_status_nxt = res_status_r;
    res_last_nxt   = res_last_r;
    ret_tnext_nxt  = ret_tnext_r;
    out_vld_nxt    = out_vld_r;
    out_id_nxt     = out_id_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;

    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          unique case (dtq_pkg::op_t'(in_chan.op))
            dtq_pkg::OP_TICK: begin
              now_nxt      = now_r + 32'd1;
              is_tick_nxt  = 1'b1;
              pend_nxt     = 1'b0;
              cnt_nxt      = '0;
              scan_idx_nxt = '0;
              chk_vld_nxt  = 1'b0;
              found_nxt    = 1'b0;
              state_nxt    = S_SCAN;
            end
            dtq_pkg::OP_ADD: begin
              res_last_nxt  = 1'b1;
              ret_tnext_nxt = 1'b0;
              state_nxt     = S_EMIT;
              if (bad_timeout) begin
                res_id_nxt     = '0;
                res_status_nxt = dtq_pkg::ST_REJECTED;
              end else if (!free_found) begin
                res_id_nxt     = '0;
                res_status_nxt = dtq_pkg::ST_FULL;
              end else begin
                ram_we              = 1'b1;
                valid_nxt[free_idx] = 1'b1;
                res_id_nxt          = next_id_r;
                res_status_nxt      = dtq_pkg::ST_ADDED;
                next_id_nxt         = nid_step;
              end
            end
            dtq_pkg::OP_CANCEL: begin
              task_nxt = in_chan.task_id;
              if (in_chan.task_id == dtq_pkg::ID_ALL) begin
                valid_nxt      = '0;
                res_id_nxt     = dtq_pkg::ID_ALL;
                res_status_nxt = dtq_pkg::ST_CANCELLED;
                res_last_nxt   = 1'b1;
                ret_tnext_nxt  = 1'b0;
                state_nxt      = S_EMIT;
              end else begin
                is_tick_nxt  = 1'b0;
                scan_idx_nxt = '0;
                chk_vld_nxt  = 1'b0;
                found_nxt    = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle, evaluate the entry read the cycle before
        if (scan_idx_r != CNT_W'(TABLE_DEPTH)) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (chk_vld_r && valid_r[chk_idx_r]) begin
          if (is_tick_r) begin
            if (ev.due && ev.better) begin
              found_nxt    = 1'b1;
              best_idx_nxt = chk_idx_r;
              best_key_nxt = ev.key;
              best_id_nxt  = ram_rdata.id;
            end
          end else if (!found_r && (ram_rdata.id == task_r)) begin
            found_nxt    = 1'b1;
            best_idx_nxt = chk_idx_r;
          end
        end

        if (scan_end) begin
          if (!is_tick_r) begin
            if (found_r) begin
              valid_nxt[best_idx_r] = 1'b0;
              res_status_nxt        = dtq_pkg::ST_CANCELLED;
            end else begin
              res_status_nxt = dtq_pkg::ST_NOT_FOUND;
            end
            res_id_nxt    = task_r;
            res_last_nxt  = 1'b1;
            ret_tnext_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else if (found_r) begin
            // hold the new expiry back; release the previous one, not last
            valid_nxt[best_idx_r] = 1'b0;
            cnt_nxt               = cnt_r + RCW'(1);
            pend_nxt              = 1'b1;
            pend_id_nxt           = best_id_r;
            if (pend_r) begin
              res_id_nxt     = pend_id_r;
              res_status_nxt = dtq_pkg::ST_EXPIRED;
              res_last_nxt   = 1'b0;
              ret_tnext_nxt  = 1'b1;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_TNEXT;
            end
          end else if (pend_r) begin
            res_id_nxt     = pend_id_r;
            res_status_nxt = dtq_pkg::ST_EXPIRED;
            res_last_nxt   = 1'b1;
            ret_tnext_nxt  = 1'b0;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_TNEXT: begin
        if (cnt_r == RCW'(dtq_pkg::MAX_RESULTS)) begin
          res_id_nxt     = pend_id_r;
          res_status_nxt = dtq_pkg::ST_EXPIRED;
          res_last_nxt   = 1'b1;
          ret_tnext_nxt  = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          found_nxt    = 1'b0;
          state_nxt    = S_SCAN;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_id_nxt     = res_id_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          state_nxt      = ret_tnext_r ? S_TNEXT : S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      next_id_r   <= 16'd1;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      is_tick_r   <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      ret_tnext_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      found_r     <= found_nxt;
      is_tick_r   <= is_tick_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      ret_tnext_r <= ret_tnext_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    best_id_r    <= best_id_nxt;
    task_r       <= task_nxt;
    pend_id_r    <= pend_id_nxt;
    res_id_r     <= res_id_nxt;
    res_status_r <= res_status_nxt;
    res_last_r   <= res_last_nxt;
    out_id_r     <= out_id_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

>>> hw/rtl/dtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/dtq_sel.sv
// Due check and deadline/id ordering compare for one scanned entry.
module dtq_sel (
  input  logic [31:0]   now_ms,
  input  dtq_pkg::entry_t cand,
  input  logic          best_found,
  input  logic [31:0]   best_key,
  input  logic [15:0]   best_id,
  output dtq_pkg::eval_t ev
);

  logic [31:0] age;
  logic [31:0] key;

  // signed distance biased so an unsigned compare orders across wrap
  assign age = now_ms - cand.deadline;
  assign key = (cand.deadline - now_ms) ^ dtq_pkg::KEY_BIAS;

  always_comb begin
    ev.key    = key;
    ev.due    = ~age[31];
    ev.better = ~best_found || (key < best_key) ||
                ((key == best_key) && (cand.id < best_id));
  end

endmodule
